// File: hdl/sie_pkg.sv
package sie_pkg;

    localparam int CAPACITY    = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef logic [VALUE_WIDTH-1:0] elem_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;

    typedef enum logic [1:0] {
        OP_APPEND_A = 2'd0,
        OP_APPEND_B = 2'd1,
        OP_COMPUTE  = 2'd2
    } op_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic signed [31:0] common_value;
        logic               last;
        logic               empty_res;
        logic               overflow;
    } out_t;

    // Sign-extend the 32-bit input beat and keep the stored width.
    function automatic elem_t widen_value(logic signed [31:0] v);
        logic signed [63:0] wide;
        wide = 64'(v);
        return wide[VALUE_WIDTH-1:0];
    endfunction

    // Stored element back to the 32-bit result field (zero-extend when narrow).
    function automatic logic [31:0] narrow_value(elem_t v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[31:0];
    endfunction

endpackage

// File: hdl/set_intersection_engine.sv
// Set intersection engine.
// Input channel s_valid/s_ready/s_data carries one op per beat: append s_data.value
// to set A, append it to set B, or compute. An append to a full set is dropped and
// raises the overflow mark carried by the next results. A compute walks the larger
// set (set B on a tie) element by element; each walked element is read in the fetch
// state, then the other set is scanned one entry per cycle from its first entry until
// the first match or its end. Each set store has a single read port.
// Matches leave on m_valid/m_ready/m_data in walk order; the final one has last set.
// A compute with no match yields one beat with empty_res and last set. After the
// final beat is loaded both sets and the overflow mark are cleared.
// s_ready is high only while no compute is running. Results pass through one output
// register: while the receiver stalls, the scan holds on the next match.
// Reset (aresetn low, synchronous) empties both sets and clears the state, the overflow
// mark and the valid flags; set contents are not cleared, only entries below the counts are ever read.
module set_intersection_engine (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sie_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output sie_pkg::out_t m_data
);

    sie_pkg::state_t state_reg, state_next;

    sie_pkg::cnt_t  count_a_reg, count_b_reg;
    logic           dropped_reg;
    logic           walk_is_a_reg;
    sie_pkg::cnt_t  nwalk_reg, nscan_reg;
    sie_pkg::idx_t  walk_idx_reg, scan_idx_reg;
    logic           pend_valid_reg;
    sie_pkg::elem_t pend_value_reg;
    logic           m_valid_reg;
    sie_pkg::out_t  m_data_reg;

    sie_pkg::elem_t mem_a [sie_pkg::CAPACITY];
    sie_pkg::elem_t mem_b [sie_pkg::CAPACITY];
    sie_pkg::elem_t rdata_a_reg, rdata_b_reg;

    sie_pkg::idx_t  walk_addr, scan_addr, addr_a, addr_b;
    sie_pkg::elem_t walk_rdata, scan_rdata, in_elem;

    logic in_fire, out_free, hit, scan_end, walk_end, a_gt_b;
    logic a_full, b_full, sets_empty;
    logic take_match, elem_done, scan_step, out_load, finish;
    logic we_a, we_b, start_compute;
    sie_pkg::out_t out_next;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign in_elem  = sie_pkg::widen_value(s_data.value);

    assign a_full     = (count_a_reg == sie_pkg::cnt_t'(sie_pkg::CAPACITY));
    assign b_full     = (count_b_reg == sie_pkg::cnt_t'(sie_pkg::CAPACITY));
    assign a_gt_b     = (count_a_reg > count_b_reg);
    assign sets_empty = (count_a_reg == '0) || (count_b_reg == '0);

    assign walk_rdata = walk_is_a_reg ? rdata_a_reg : rdata_b_reg;
    assign scan_rdata = walk_is_a_reg ? rdata_b_reg : rdata_a_reg;
    assign hit        = (walk_rdata == scan_rdata);
    assign scan_end   = (sie_pkg::cnt_t'(scan_idx_reg) + sie_pkg::cnt_t'(1)) == nscan_reg;
    assign walk_end   = (sie_pkg::cnt_t'(walk_idx_reg) + sie_pkg::cnt_t'(1)) == nwalk_reg;

    assign addr_a = walk_is_a_reg ? walk_addr : scan_addr;
    assign addr_b = walk_is_a_reg ? scan_addr : walk_addr;

    assign s_ready = (state_reg == sie_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sie_pkg::ST_IDLE: begin
                if (start_compute) begin
                    state_next = sets_empty ? sie_pkg::ST_FLUSH : sie_pkg::ST_FETCH;
                end
            end
            sie_pkg::ST_FETCH: begin
                state_next = sie_pkg::ST_SCAN;
            end
            sie_pkg::ST_SCAN: begin
                if (elem_done) begin
                    state_next = walk_end ? sie_pkg::ST_FLUSH : sie_pkg::ST_FETCH;
                end
            end
            sie_pkg::ST_FLUSH: begin
                if (out_free) begin
                    state_next = sie_pkg::ST_IDLE;
                end
            end
            default: state_next = sie_pkg::ST_IDLE;
        endcase
    end

    // Datapath control
    always_comb begin
        walk_addr     = walk_idx_reg;
        scan_addr     = scan_idx_reg;
        take_match    = 1'b0;
        elem_done     = 1'b0;
        scan_step     = 1'b0;
        out_load      = 1'b0;
        finish        = 1'b0;
        we_a          = 1'b0;
        we_b          = 1'b0;
        start_compute = 1'b0;
        out_next      = '0;
        out_next.overflow = dropped_reg;
        unique case (state_reg)
            sie_pkg::ST_IDLE: begin
                if (in_fire) begin
                    priority case (s_data.op)
                        sie_pkg::OP_APPEND_A: we_a = !a_full;
                        sie_pkg::OP_APPEND_B: we_b = !b_full;
                        sie_pkg::OP_COMPUTE:  start_compute = 1'b1;
                        default: ;
                    endcase
                end
            end
            sie_pkg::ST_FETCH: begin
                scan_addr = '0;
            end
            sie_pkg::ST_SCAN: begin
                if (hit) begin
                    // hold on the match until the older pending one can leave
                    if (!pend_valid_reg || out_free) begin
                        take_match = 1'b1;
                        elem_done  = 1'b1;
                        out_load   = pend_valid_reg;
                        out_next.common_value = sie_pkg::narrow_value(pend_value_reg);
                    end
                end else if (scan_end) begin
                    elem_done = 1'b1;
                end else begin
                    scan_step = 1'b1;
                    scan_addr = scan_idx_reg + sie_pkg::idx_t'(1);
                end
            end
            sie_pkg::ST_FLUSH: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    finish         = 1'b1;
                    out_next.last  = 1'b1;
                    if (pend_valid_reg) begin
                        out_next.common_value = sie_pkg::narrow_value(pend_value_reg);
                    end else begin
                        out_next.empty_res = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sie_pkg::ST_IDLE;
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            dropped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (we_a) begin
                count_a_reg <= count_a_reg + sie_pkg::cnt_t'(1);
            end
            if (we_b) begin
                count_b_reg <= count_b_reg + sie_pkg::cnt_t'(1);
            end
            if (in_fire && ((s_data.op == sie_pkg::OP_APPEND_A && a_full) ||
                            (s_data.op == sie_pkg::OP_APPEND_B && b_full))) begin
                dropped_reg <= 1'b1;
            end
            if (start_compute) begin
                pend_valid_reg <= 1'b0;
            end else if (take_match) begin
                pend_valid_reg <= 1'b1;
            end
            if (finish) begin
                count_a_reg    <= '0;
                count_b_reg    <= '0;
                dropped_reg    <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and walk bookkeeping
    always_ff @(posedge aclk) begin
        if (start_compute) begin
            walk_is_a_reg <= a_gt_b;
            nwalk_reg     <= a_gt_b ? count_a_reg : count_b_reg;
            nscan_reg     <= a_gt_b ? count_b_reg : count_a_reg;
            walk_idx_reg  <= '0;
        end else if (elem_done) begin
            walk_idx_reg  <= walk_idx_reg + sie_pkg::idx_t'(1);
        end
        if (state_reg == sie_pkg::ST_FETCH) begin
            scan_idx_reg <= '0;
        end else if (scan_step) begin
            scan_idx_reg <= scan_idx_reg + sie_pkg::idx_t'(1);
        end
        if (take_match) begin
            pend_value_reg <= walk_rdata;
        end
        if (out_load) begin
            m_data_reg <= out_next;
        end
    end

    // Set stores: writes only while idle; registered reads every cycle, used only during a compute
    always_ff @(posedge aclk) begin
        if (we_a) begin
            mem_a[count_a_reg[sie_pkg::IDX_W-1:0]] <= in_elem;
        end
        rdata_a_reg <= mem_a[addr_a];
    end

    always_ff @(posedge aclk) begin
        if (we_b) begin
            mem_b[count_b_reg[sie_pkg::IDX_W-1:0]] <= in_elem;
        end
        rdata_b_reg <= mem_b[addr_b];
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_a_reg <= sie_pkg::cnt_t'(sie_pkg::CAPACITY) &&
        count_b_reg <= sie_pkg::cnt_t'(sie_pkg::CAPACITY))
        else $error("set count beyond capacity");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> (count_a_reg == '0 && count_b_reg == '0 && !dropped_reg))
        else $error("compute did not clear the sets");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.empty_res |-> m_data.last && m_data.common_value == '0)
        else $error("empty result without last");

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sie_pkg::ST_IDLE |-> !pend_valid_reg)
        else $error("pending match left while idle");

    a_drop_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_data.op == sie_pkg::OP_APPEND_A && a_full |=> dropped_reg)
        else $error("dropped append not flagged");

endmodule
